// ===== rtl/core/ofm_pkg.sv =====
// ----------------------------------------------------------------------------
// ofm_pkg
// Shared types, constants and helper functions for the orbit-frame matrix
// pipeline: vector formats, block normalization helpers, pipeline depths.
// ----------------------------------------------------------------------------
package ofm_pkg;

    // Input component width; sign taken from bit IN_WIDTH-1
    localparam int IN_WIDTH      = 32;
    // Fraction bits of the unit-axis outputs
    localparam int OUT_FRAC_BITS = 30;
    // Block normalization puts the largest magnitude in [2^30, 2^31)
    localparam int NORM_TOP      = 30;

    // Divider: one leading step plus OUT_FRAC_BITS+1 fraction steps
    localparam int DIV_STEPS = OUT_FRAC_BITS + 2;
    localparam int Q_W       = OUT_FRAC_BITS + 2;
    localparam int SQRT_STEPS = 32;

    // Unit scaling latency: square, sum, square root, divide, round
    localparam int UNIT_LAT = 2 + SQRT_STEPS + DIV_STEPS + 1;

    // Output magnitude limit: min(2^OUT_FRAC_BITS, 2^31-1)
    localparam logic [63:0] OUT_ONE = 64'd1 << OUT_FRAC_BITS;
    localparam logic [63:0] OUT_MAX = 64'd2147483647;
    localparam logic [63:0] OUT_LIM = (OUT_ONE > OUT_MAX) ? OUT_MAX : OUT_ONE;

    // Block-normalized vector: sign and 31-bit magnitude per component
    typedef struct packed {
        logic [2:0]       neg;
        logic [2:0][30:0] mag;
    } t_vec;

    // Side data carried along a cross-product stage
    typedef struct packed {
        logic ok;
        t_vec s0;
        t_vec s1;
    } t_xside;

    // Position of the highest set bit
    function automatic logic [5:0] lead_one(input logic [63:0] x);
        logic [5:0] t;
        t = '0;
        for (int i = 0; i < 64; i++) begin
            if (x[i]) begin
                t = 6'(i);
            end
        end
        return t;
    endfunction

    // Shift a magnitude so that bit 'top' lands on NORM_TOP
    function automatic logic [30:0] norm_shift(input logic [63:0] m, input logic [5:0] top);
        logic [63:0] s;
        if (top > 6'(NORM_TOP)) begin
            s = m >> (top - 6'(NORM_TOP));
        end else begin
            s = m << (6'(NORM_TOP) - top);
        end
        return s[30:0];
    endfunction

    // Signed 32-bit value from sign and magnitude
    function automatic logic signed [31:0] to_s32(input logic neg, input logic [30:0] mag);
        logic signed [31:0] v;
        v = $signed({1'b0, mag});
        return neg ? -v : v;
    endfunction

endpackage

// ===== rtl/core/orbit_frame_matrix_from_pos_vel_top.sv =====
// ----------------------------------------------------------------------------
// orbit_frame_matrix_from_pos_vel_top
// Orbit-frame rotation matrix from a position and velocity word.
// ----------------------------------------------------------------------------
// One word (position and velocity) enters per clock; busy is never asserted.
// Each word gives one result word, marked by o_valid for one cycle; the depth
// is set by the 32-stage square root and the 32-stage divide of the unit
// scaling, after a 3-stage input normalization and two 5-stage cross
// products. Outputs are Q2.30 axis columns; a zero or parallel input gives
// o_degenerate with all nine axis fields zero. The receiver cannot stall, so
// a result must be taken in its cycle.
module orbit_frame_matrix_from_pos_vel_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_y,
    input  logic [31:0] i_pos_z,
    input  logic [31:0] i_vel_x,
    input  logic [31:0] i_vel_y,
    input  logic [31:0] i_vel_z,
    output logic        o_valid,
    output logic [31:0] o_xaxis_x,
    output logic [31:0] o_xaxis_y,
    output logic [31:0] o_xaxis_z,
    output logic [31:0] o_yaxis_x,
    output logic [31:0] o_yaxis_y,
    output logic [31:0] o_yaxis_z,
    output logic [31:0] o_zaxis_x,
    output logic [31:0] o_zaxis_y,
    output logic [31:0] o_zaxis_z,
    output logic        o_degenerate
);

    assign busy = 1'b0;

    // sign extend, negate position, split into sign and magnitude
    logic [2:0][31:0]  w_raw [2];
    logic [1:0][2:0][63:0] n_p1_mag;
    logic [1:0][2:0]   n_p1_neg;
    assign w_raw[0] = {i_pos_z, i_pos_y, i_pos_x};
    assign w_raw[1] = {i_vel_z, i_vel_y, i_vel_x};

    always_comb begin
        logic signed [63:0] s;
        for (int k = 0; k < 2; k++) begin
            for (int i = 0; i < 3; i++) begin
                s = 64'($signed(w_raw[k][i][ofm_pkg::IN_WIDTH-1:0]));
                if (k == 0) begin
                    s = -s;
                end
                n_p1_neg[k][i] = s[63];
                n_p1_mag[k][i] = s[63] ? 64'(-s) : 64'(s);
            end
        end
    end

    logic                  r_p1v, r_p2v, r_p3v;
    logic [1:0][2:0][63:0] r_p1_mag, r_p2_mag;
    logic [1:0][2:0]       r_p1_neg, r_p2_neg;
    logic [1:0][5:0]       r_p2_top;
    logic                  r_p2_ok, r_p3_ok;
    ofm_pkg::t_vec         r_p3_vec [2];

    // advance valid bits of the input normalization
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1v <= 1'b0;
            r_p2v <= 1'b0;
            r_p3v <= 1'b0;
        end else begin
            r_p1v <= start && !busy;
            r_p2v <= r_p1v;
            r_p3v <= r_p2v;
        end
    end

    // magnitude, leading one, shift
    always_ff @(posedge i_clk) begin
        logic [63:0] all [2];
        r_p1_mag <= n_p1_mag;
        r_p1_neg <= n_p1_neg;
        for (int k = 0; k < 2; k++) begin
            all[k] = r_p1_mag[k][0] | r_p1_mag[k][1] | r_p1_mag[k][2];
            r_p2_top[k] <= ofm_pkg::lead_one(all[k]);
        end
        r_p2_ok  <= (all[0] != '0) && (all[1] != '0);
        r_p2_mag <= r_p1_mag;
        r_p2_neg <= r_p1_neg;
        for (int k = 0; k < 2; k++) begin
            r_p3_vec[k].neg <= r_p2_neg[k];
            for (int i = 0; i < 3; i++) begin
                r_p3_vec[k].mag[i] <= ofm_pkg::norm_shift(r_p2_mag[k][i], r_p2_top[k]);
            end
        end
        r_p3_ok <= r_p2_ok;
    end

    // two cross products: Y = Z x V, then X = Y x Z
    ofm_pkg::t_vec   w_xa   [2];
    ofm_pkg::t_vec   w_xb   [2];
    ofm_pkg::t_xside w_xin  [2];
    logic            w_xvin [2];
    ofm_pkg::t_vec   w_xm   [2];
    ofm_pkg::t_xside w_xout [2];
    logic            w_xvout[2];

    assign w_xa[0]      = r_p3_vec[0];
    assign w_xb[0]      = r_p3_vec[1];
    assign w_xin[0]     = '{ok: r_p3_ok, s0: r_p3_vec[0], s1: r_p3_vec[1]};
    assign w_xvin[0]    = r_p3v;
    assign w_xa[1]      = w_xm[0];
    assign w_xb[1]      = w_xout[0].s0;
    assign w_xin[1]     = '{ok: w_xout[0].ok, s0: w_xout[0].s0, s1: w_xm[0]};
    assign w_xvin[1]    = w_xvout[0];

    for (genvar k = 0; k < 2; k++) begin : g_cross
        logic               r_v1, r_v2, r_v3, r_v4, r_v5;
        ofm_pkg::t_xside    r_sd1, r_sd2, r_sd3, r_sd4, r_sd5;
        logic signed [63:0] r_prod [6];
        logic signed [63:0] r_diff [3];
        logic [2:0][63:0]   r_mag3, r_mag4;
        logic [2:0]         r_neg3, r_neg4;
        logic [5:0]         r_top;
        ofm_pkg::t_vec      r_res;
        logic signed [31:0] w_a [3];
        logic signed [31:0] w_b [3];

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                w_a[i] = ofm_pkg::to_s32(w_xa[k].neg[i], w_xa[k].mag[i]);
                w_b[i] = ofm_pkg::to_s32(w_xb[k].neg[i], w_xb[k].mag[i]);
            end
        end

        // advance stage valid bits
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v1 <= 1'b0;
                r_v2 <= 1'b0;
                r_v3 <= 1'b0;
                r_v4 <= 1'b0;
                r_v5 <= 1'b0;
            end else begin
                r_v1 <= w_xvin[k];
                r_v2 <= r_v1;
                r_v3 <= r_v2;
                r_v4 <= r_v3;
                r_v5 <= r_v4;
            end
        end

        // products, differences, magnitude, leading one, shift
        always_ff @(posedge i_clk) begin
            logic [63:0] all;
            r_prod[0] <= 64'(w_a[1]) * 64'(w_b[2]);
            r_prod[1] <= 64'(w_a[2]) * 64'(w_b[1]);
            r_prod[2] <= 64'(w_a[2]) * 64'(w_b[0]);
            r_prod[3] <= 64'(w_a[0]) * 64'(w_b[2]);
            r_prod[4] <= 64'(w_a[0]) * 64'(w_b[1]);
            r_prod[5] <= 64'(w_a[1]) * 64'(w_b[0]);
            r_sd1     <= w_xin[k];

            r_diff[0] <= r_prod[0] - r_prod[1];
            r_diff[1] <= r_prod[2] - r_prod[3];
            r_diff[2] <= r_prod[4] - r_prod[5];
            r_sd2     <= r_sd1;

            for (int i = 0; i < 3; i++) begin
                r_neg3[i] <= r_diff[i][63];
                r_mag3[i] <= r_diff[i][63] ? 64'(-r_diff[i]) : 64'(r_diff[i]);
            end
            r_sd3 <= r_sd2;

            all       = r_mag3[0] | r_mag3[1] | r_mag3[2];
            r_top     <= ofm_pkg::lead_one(all);
            r_mag4    <= r_mag3;
            r_neg4    <= r_neg3;
            r_sd4     <= '{ok: r_sd3.ok && (all != '0), s0: r_sd3.s0, s1: r_sd3.s1};

            r_res.neg <= r_neg4;
            for (int i = 0; i < 3; i++) begin
                r_res.mag[i] <= ofm_pkg::norm_shift(r_mag4[i], r_top);
            end
            r_sd5 <= r_sd4;
        end

        assign w_xm[k]    = r_res;
        assign w_xout[k]  = r_sd5;
        assign w_xvout[k] = r_v5;
    end

    // unit scaling of the three axes in parallel
    logic [2:0][31:0] w_ux, w_uy, w_uz;

    ofm_unit u_unit_x (.i_clk(i_clk), .i_vec(w_xm[1]),        .o_axis(w_ux));
    ofm_unit u_unit_y (.i_clk(i_clk), .i_vec(w_xout[1].s1),   .o_axis(w_uy));
    ofm_unit u_unit_z (.i_clk(i_clk), .i_vec(w_xout[1].s0),   .o_axis(w_uz));

    // carry valid and frame-exists flag alongside the unit pipelines
    logic [ofm_pkg::UNIT_LAT-1:0] r_uvld;
    logic [ofm_pkg::UNIT_LAT-1:0] r_uok;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uvld <= '0;
        end else begin
            r_uvld <= {r_uvld[ofm_pkg::UNIT_LAT-2:0], w_xvout[1]};
        end
        r_uok <= {r_uok[ofm_pkg::UNIT_LAT-2:0], w_xout[1].ok};
    end

    // output word: drop axes to zero when no frame exists
    logic             r_ovld, r_odeg;
    logic [2:0][31:0] r_ox, r_oy, r_oz;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else begin
            r_ovld <= r_uvld[ofm_pkg::UNIT_LAT-1];
        end
        r_odeg <= !r_uok[ofm_pkg::UNIT_LAT-1];
        r_ox   <= r_uok[ofm_pkg::UNIT_LAT-1] ? w_ux : '0;
        r_oy   <= r_uok[ofm_pkg::UNIT_LAT-1] ? w_uy : '0;
        r_oz   <= r_uok[ofm_pkg::UNIT_LAT-1] ? w_uz : '0;
    end

    assign o_valid      = r_ovld;
    assign o_degenerate = r_odeg;
    assign o_xaxis_x    = r_ox[0];
    assign o_xaxis_y    = r_ox[1];
    assign o_xaxis_z    = r_ox[2];
    assign o_yaxis_x    = r_oy[0];
    assign o_yaxis_y    = r_oy[1];
    assign o_yaxis_z    = r_oy[2];
    assign o_zaxis_x    = r_oz[0];
    assign o_zaxis_y    = r_oz[1];
    assign o_zaxis_z    = r_oz[2];

endmodule

// ===== rtl/core/ofm_unit.sv =====
// ----------------------------------------------------------------------------
// ofm_unit
// Unit scaling of one block-normalized vector: squared length, pipelined
// integer square root, pipelined restoring divide, round and clamp.
// ----------------------------------------------------------------------------
module ofm_unit (
    input  logic                   i_clk,
    input  ofm_pkg::t_vec          i_vec,
    output logic [2:0][31:0]       o_axis
);

    // square each component
    logic [2:0][63:0] r_sq;
    ofm_pkg::t_vec    r_sq_vec;
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_sq[i] <= 64'(i_vec.mag[i]) * 64'(i_vec.mag[i]);
        end
        r_sq_vec <= i_vec;
    end

    // sum of squares feeds the root pipeline
    logic [63:0]   r_sn  [0:ofm_pkg::SQRT_STEPS];
    logic [63:0]   r_sr  [0:ofm_pkg::SQRT_STEPS];
    ofm_pkg::t_vec r_svec[0:ofm_pkg::SQRT_STEPS];
    always_ff @(posedge i_clk) begin
        r_sn[0]   <= r_sq[0] + r_sq[1] + r_sq[2];
        r_sr[0]   <= '0;
        r_svec[0] <= r_sq_vec;
    end

    // one root digit per stage
    for (genvar j = 0; j < ofm_pkg::SQRT_STEPS; j++) begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
        logic [63:0] n_try;
        assign n_try = r_sr[j] + BIT;
        always_ff @(posedge i_clk) begin
            if (r_sn[j] >= n_try) begin
                r_sn[j+1] <= r_sn[j] - n_try;
                r_sr[j+1] <= (r_sr[j] >> 1) + BIT;
            end else begin
                r_sn[j+1] <= r_sn[j];
                r_sr[j+1] <= r_sr[j] >> 1;
            end
            r_svec[j+1] <= r_svec[j];
        end
    end

    // divide stages: remainder, quotient, divisor, signs
    logic [2:0][33:0]              r_rem [1:ofm_pkg::DIV_STEPS];
    logic [2:0][ofm_pkg::Q_W-1:0]  r_q   [1:ofm_pkg::DIV_STEPS];
    logic [31:0]                   r_dn  [1:ofm_pkg::DIV_STEPS];
    logic [2:0]                    r_dneg[1:ofm_pkg::DIV_STEPS];

    for (genvar j = 0; j < ofm_pkg::DIV_STEPS; j++) begin : g_div
        logic [2:0][33:0]             cur_rem;
        logic [2:0][ofm_pkg::Q_W-1:0] cur_q;
        logic [31:0]                  cur_n;
        logic [2:0]                   cur_neg;
        logic [2:0][33:0]             n_rem;
        logic [2:0][ofm_pkg::Q_W-1:0] n_q;

        if (j == 0) begin : g_first
            always_comb begin
                for (int i = 0; i < 3; i++) begin
                    cur_rem[i] = 34'(r_svec[ofm_pkg::SQRT_STEPS].mag[i]);
                    cur_q[i]   = '0;
                end
                cur_n   = r_sr[ofm_pkg::SQRT_STEPS][31:0];
                cur_neg = r_svec[ofm_pkg::SQRT_STEPS].neg;
            end
        end else begin : g_next
            always_comb begin
                for (int i = 0; i < 3; i++) begin
                    cur_rem[i] = {r_rem[j][i][32:0], 1'b0};
                    cur_q[i]   = {r_q[j][i][ofm_pkg::Q_W-2:0], 1'b0};
                end
                cur_n   = r_dn[j];
                cur_neg = r_dneg[j];
            end
        end

        // compare and subtract, one quotient bit per component
        always_comb begin
            for (int i = 0; i < 3; i++) begin
                if (cur_rem[i] >= 34'(cur_n)) begin
                    n_rem[i] = cur_rem[i] - 34'(cur_n);
                    n_q[i]   = cur_q[i] | ofm_pkg::Q_W'(1);
                end else begin
                    n_rem[i] = cur_rem[i];
                    n_q[i]   = cur_q[i];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[j+1]  <= n_rem;
            r_q[j+1]    <= n_q;
            r_dn[j+1]   <= cur_n;
            r_dneg[j+1] <= cur_neg;
        end
    end

    // round half up, clamp, apply sign
    logic [2:0][31:0] r_out;
    always_ff @(posedge i_clk) begin
        logic [63:0] rnd;
        for (int i = 0; i < 3; i++) begin
            rnd = (64'(r_q[ofm_pkg::DIV_STEPS][i]) + 64'd1) >> 1;
            if (rnd > ofm_pkg::OUT_LIM) begin
                rnd = ofm_pkg::OUT_LIM;
            end
            r_out[i] <= r_dneg[ofm_pkg::DIV_STEPS][i] ? (32'd0 - rnd[31:0]) : rnd[31:0];
        end
    end

    assign o_axis = r_out;

endmodule

// ===== rtl/core/ofm_checker.sv =====
// ----------------------------------------------------------------------------
// ofm_checker
// Port-level checks of the orbit-frame matrix block, bound to the top level.
// ----------------------------------------------------------------------------
module ofm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [31:0] o_xaxis_x,
    input logic [31:0] o_xaxis_y,
    input logic [31:0] o_xaxis_z,
    input logic [31:0] o_yaxis_x,
    input logic [31:0] o_yaxis_y,
    input logic [31:0] o_yaxis_z,
    input logic [31:0] o_zaxis_x,
    input logic [31:0] o_zaxis_y,
    input logic [31:0] o_zaxis_z,
    input logic        o_degenerate
);

    // a degenerate word carries an all-zero matrix
    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |->
            o_xaxis_x == '0 && o_xaxis_y == '0 && o_xaxis_z == '0 &&
            o_yaxis_x == '0 && o_yaxis_y == '0 && o_yaxis_z == '0 &&
            o_zaxis_x == '0 && o_zaxis_y == '0 && o_zaxis_z == '0)
        else $error("degenerate word with nonzero axes");

    // a valid frame has a nonzero Z axis
    a_z_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_degenerate |->
            o_zaxis_x != '0 || o_zaxis_y != '0 || o_zaxis_z != '0)
        else $error("frame with zero Z axis");

    // diagonal axis components (X.x, Y.y, Z.z) stay within unit magnitude
    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |->
            $signed(o_xaxis_x) <= 32'sd1073741824 && $signed(o_xaxis_x) >= -32'sd1073741824 &&
            $signed(o_yaxis_y) <= 32'sd1073741824 && $signed(o_yaxis_y) >= -32'sd1073741824 &&
            $signed(o_zaxis_z) <= 32'sd1073741824 && $signed(o_zaxis_z) >= -32'sd1073741824)
        else $error("axis component beyond unit range");

    // the pipeline never holds off a command
    a_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> !busy)
        else $error("busy raised against a command");

endmodule

bind orbit_frame_matrix_from_pos_vel_top ofm_checker u_ofm_checker (.*);

// ===== tb/orbit_frame_matrix_from_pos_vel_top_tb.sv =====
// ----------------------------------------------------------------------------
// orbit_frame_matrix_from_pos_vel_top_tb
// Drives position/velocity words into the orbit-frame matrix block and
// checks every result word against a bit-exact fixed-point frame predictor.
// ----------------------------------------------------------------------------
module orbit_frame_matrix_from_pos_vel_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_LIMIT  = 400000;
    localparam int PIPE_DEPTH = 81;

    typedef struct {
        logic [31:0] axis [9];
        logic        degen;
    } t_frame;

    // Sign-extend a raw input component from IN_WIDTH bits
    function automatic longint sext_comp(input logic [31:0] raw);
        logic [63:0] v;
        v = 64'(raw);
        v = v & ((64'd1 << ofm_pkg::IN_WIDTH) - 1);
        if (v[ofm_pkg::IN_WIDTH-1]) begin
            v = v | ~((64'd1 << ofm_pkg::IN_WIDTH) - 1);
        end
        return longint'(v);
    endfunction

    // Scale a vector so its largest magnitude sits in [2^30, 2^31)
    function automatic bit scale_vec(input longint a [3], output longint o [3]);
        logic [63:0] mag [3];
        logic [63:0] all;
        int          top;
        all = '0;
        top = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = a[i] < 0 ? 64'(-a[i]) : 64'(a[i]);
            all    = all | mag[i];
        end
        for (int i = 0; i < 3; i++) o[i] = 0;
        if (all == 0) return 0;
        for (int i = 0; i < 64; i++) if (all[i]) top = i;
        for (int i = 0; i < 3; i++) begin
            if (top > ofm_pkg::NORM_TOP) mag[i] = mag[i] >> (top - ofm_pkg::NORM_TOP);
            else                         mag[i] = mag[i] << (ofm_pkg::NORM_TOP - top);
            o[i] = a[i] < 0 ? -longint'(mag[i]) : longint'(mag[i]);
        end
        return 1;
    endfunction

    function automatic void cross_vec(input longint a [3], input longint b [3],
                                      output longint c [3]);
        c[0] = a[1] * b[2] - a[2] * b[1];
        c[1] = a[2] * b[0] - a[0] * b[2];
        c[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    function automatic logic [63:0] root_floor(input logic [63:0] n);
        logic [63:0] res, bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Turn a normalized vector into three rounded unit components
    function automatic void unit_axis(input longint m [3], inout t_frame f, input int base);
        logic [63:0] mag [3];
        logic [63:0] sum, n, q, rem, r;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = m[i] < 0 ? 64'(-m[i]) : 64'(m[i]);
            sum    = sum + mag[i] * mag[i];
        end
        n = root_floor(sum);
        for (int i = 0; i < 3; i++) begin
            f.axis[base+i] = '0;
            if (n != 0) begin
                q   = 0;
                rem = mag[i];
                if (rem >= n) begin
                    q   = 1;
                    rem = rem - n;
                end
                for (int k = 0; k < ofm_pkg::OUT_FRAC_BITS + 1; k++) begin
                    rem = rem << 1;
                    q   = q << 1;
                    if (rem >= n) begin
                        q   = q | 1;
                        rem = rem - n;
                    end
                end
                r = (q + 1) >> 1;
                if (r > ofm_pkg::OUT_LIM) r = ofm_pkg::OUT_LIM;
                f.axis[base+i] = m[i] < 0 ? 32'(-r) : 32'(r);
            end
        end
    endfunction

    function automatic t_frame predict_frame(input logic [31:0] p [3], input logic [31:0] v [3]);
        t_frame f;
        longint zr [3], vr [3], zm [3], vm [3], yr [3], ym [3], xr [3], xm [3];
        bit     ok;
        for (int i = 0; i < 3; i++) begin
            zr[i] = -sext_comp(p[i]);
            vr[i] = sext_comp(v[i]);
        end
        ok = scale_vec(zr, zm);
        ok = scale_vec(vr, vm) && ok;
        if (ok) begin
            cross_vec(zm, vm, yr);
            ok = scale_vec(yr, ym);
        end
        if (ok) begin
            cross_vec(ym, zm, xr);
            ok = scale_vec(xr, xm);
        end
        for (int i = 0; i < 9; i++) f.axis[i] = '0;
        f.degen = !ok;
        if (ok) begin
            unit_axis(xm, f, 0);
            unit_axis(ym, f, 3);
            unit_axis(zm, f, 6);
        end
        return f;
    endfunction

    // Holds the frames still owed by the block and checks arrivals in order
    class frame_board;
        t_frame pending [$];
        int     errors;

        function void note_word(input logic [31:0] p [3], input logic [31:0] v [3]);
            pending.push_back(predict_frame(p, v));
        endfunction

        function void check_word(input t_frame got);
            t_frame exp_f;
            if (pending.size() == 0) begin
                $display("%0t: result word with none pending", $time);
                errors++;
                return;
            end
            exp_f = pending.pop_front();
            for (int i = 0; i < 9; i++) begin
                if (got.axis[i] !== exp_f.axis[i]) begin
                    $display("%0t: axis field %0d expected %h actual %h",
                             $time, i, exp_f.axis[i], got.axis[i]);
                    errors++;
                end
            end
            if (got.degen !== exp_f.degen) begin
                $display("%0t: degenerate expected %b actual %b",
                         $time, exp_f.degen, got.degen);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        start = 0;
    logic        busy;
    logic [31:0] i_pos_x = '0, i_pos_y = '0, i_pos_z = '0;
    logic [31:0] i_vel_x = '0, i_vel_y = '0, i_vel_z = '0;
    logic        o_valid;
    logic [31:0] o_xaxis_x, o_xaxis_y, o_xaxis_z;
    logic [31:0] o_yaxis_x, o_yaxis_y, o_yaxis_z;
    logic [31:0] o_zaxis_x, o_zaxis_y, o_zaxis_z;
    logic        o_degenerate;

    frame_board board = new();
    int         cycles = 0;

    orbit_frame_matrix_from_pos_vel_top i_dut (.*);

    always #5 i_clk = ~i_clk;

    // Sample result words and run the cycle limit
    always @(posedge i_clk) begin
        t_frame got;
        cycles <= cycles + 1;
        if (i_rst_n && o_valid) begin
            got.axis[0] = o_xaxis_x; got.axis[1] = o_xaxis_y; got.axis[2] = o_xaxis_z;
            got.axis[3] = o_yaxis_x; got.axis[4] = o_yaxis_y; got.axis[5] = o_yaxis_z;
            got.axis[6] = o_zaxis_x; got.axis[7] = o_zaxis_y; got.axis[8] = o_zaxis_z;
            got.degen   = o_degenerate;
            board.check_word(got);
        end
        if (cycles > RUN_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Send one word; hold start until accepted
    task automatic send_word(input logic [31:0] p [3], input logic [31:0] v [3]);
        i_pos_x = p[0]; i_pos_y = p[1]; i_pos_z = p[2];
        i_vel_x = v[0]; i_vel_y = v[1]; i_vel_z = v[2];
        start   = 1;
        do @(posedge i_clk); while (busy);
        board.note_word(p, v);
        @(negedge i_clk);
    endtask

    task automatic idle_cycles(input int n);
        start = 0;
        repeat (n) @(negedge i_clk);
    endtask

    // Random component: full range, small, extreme, shifted, zero or masked magnitudes
    function automatic logic [31:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 16)) - 8);
            2: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            3: return 32'($signed($urandom()) >>> $urandom_range(0, 31));
            4: return 32'h0;
            default: return $urandom() & ((32'd1 << $urandom_range(1, 31)) - 1);
        endcase
    endfunction

    initial begin
        logic [31:0] p [3], v [3];
        logic [31:0] corner [6];
        int          gap;
        corner = '{32'h0, 32'h1, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000};
        repeat (7) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        // Directed: zero vectors, parallel and antiparallel, extremes, axes
        p = '{0, 0, 0};           v = '{1, 2, 3};           send_word(p, v);
        p = '{5, 0, 0};           v = '{0, 0, 0};           send_word(p, v);
        p = '{1, 2, 3};           v = '{2, 4, 6};           send_word(p, v);
        p = '{1, 2, 3};           v = '{-1, -2, -3};        send_word(p, v);
        p = '{7000000, 0, 0};     v = '{0, 7500, 0};        send_word(p, v);
        p = '{0, 0, -6400};       v = '{0, 8, 0};           send_word(p, v);
        p = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        v = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff}; send_word(p, v);
        p = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
        v = '{32'h7fff_ffff, 32'h7fff_fffe, 32'h7fff_ffff}; send_word(p, v);
        p = '{32'h7fff_ffff, 1, 0};  v = '{32'h7fff_fffe, 1, 0}; send_word(p, v);
        p = '{1, 0, 0};           v = '{0, 0, -1};          send_word(p, v);
        p = '{-1, -1, -1};        v = '{32'hffff_ffff, 0, 1}; send_word(p, v);
        for (int i = 0; i < 6; i++) begin
            p = '{corner[i], corner[(i+1)%6], corner[(i+2)%6]};
            v = '{corner[(i+3)%6], corner[(i+4)%6], corner[(i+5)%6]};
            send_word(p, v);
        end

        // Drain fully once before random traffic
        idle_cycles(1);
        while (board.pending.size() != 0) @(negedge i_clk);

        // Random bursts with random gaps, some back-to-back stretches
        for (int n = 0; n < 1950; ) begin
            int burst;
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst; b++, n++) begin
                for (int i = 0; i < 3; i++) begin
                    p[i] = rand_comp();
                    v[i] = rand_comp();
                end
                if ($urandom_range(0, 15) == 0) begin
                    for (int i = 0; i < 3; i++) v[i] = 32'($signed(p[i]) * -1);
                end
                send_word(p, v);
            end
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            if ($urandom_range(0, 30) == 0) gap = PIPE_DEPTH + 5;
            if (gap != 0) idle_cycles(gap);
        end
        idle_cycles(1);

        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (PIPE_DEPTH + 20) @(negedge i_clk);
        if (board.errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
